// ----- sv/button_press_classifier_assert.svh -----
// Assertion macros for the button press classifier checker.
`ifndef BUTTON_PRESS_CLASSIFIER_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_ASSERT_SVH

// Checked at every edge, including while reset is held.
`define BPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only outside reset.
`define BPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ----- sv/bpc_pkg.sv -----
// Types, constants and register codes for the button press classifier.
package bpc_pkg;

  localparam int NUM_BUTTONS_DEF = 8;
  localparam int BTN_W           = 3;
  localparam int CNT_W           = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [CNT_W-1:0] DEBOUNCE_DEF = 16'd15;
  localparam logic [CNT_W-1:0] LONG_DEF     = 16'd1000;
  localparam logic [CNT_W-1:0] HOLD_DEF     = 16'd4000;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 2'd2;

  // Event codes.
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_SHORT = 2'd1;
  localparam logic [1:0] EV_LONG  = 2'd2;
  localparam logic [1:0] EV_HOLD  = 2'd3;

  typedef struct packed {
    logic [BTN_W-1:0] button;
    logic             pressed;
  } sample_t;

  typedef struct packed {
    logic [BTN_W-1:0] event_button;
    logic [1:0]       event_res;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0] pressed_count;
    logic [CNT_W-1:0] released_count;
    logic             debounced_level;
    logic             hold_reported;
  } entry_t;

  typedef struct packed {
    logic [CNT_W-1:0] debounce_ticks;
    logic [CNT_W-1:0] long_press_ticks;
    logic [CNT_W-1:0] hold_ticks;
  } cfg_t;

  localparam entry_t ENTRY_RESET = '{
    pressed_count:   '0,
    released_count:  '0,
    debounced_level: 1'b1,
    hold_reported:   1'b1
  };

endpackage

// ----- sv/bpc_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module bpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/bpc_update.sv -----
// Per-sample state update and event classification for one button entry.
module bpc_update (
  input  bpc_pkg::entry_t cur,
  input  logic            pressed,
  input  bpc_pkg::cfg_t   cfg,
  output bpc_pkg::entry_t nxt,
  output logic [1:0]      ev
);

  logic [bpc_pkg::CNT_W-1:0] pc_inc;
  logic [bpc_pkg::CNT_W-1:0] rc_inc;

  assign pc_inc = (cur.pressed_count == bpc_pkg::CNT_MAX) ? cur.pressed_count
                                                          : cur.pressed_count + 1'b1;
  assign rc_inc = (cur.released_count == bpc_pkg::CNT_MAX) ? cur.released_count
                                                           : cur.released_count + 1'b1;

  always_comb begin
    nxt = cur;
    ev  = bpc_pkg::EV_NONE;
    if (pressed) begin
      nxt.pressed_count = pc_inc;
      // A debounced press starts a new pressed interval.
      if (!cur.debounced_level && (pc_inc > cfg.debounce_ticks)) begin
        nxt.released_count  = '0;
        nxt.debounced_level = 1'b1;
      end
      if ((pc_inc > cfg.hold_ticks) && !cur.hold_reported) begin
        ev                = bpc_pkg::EV_HOLD;
        nxt.hold_reported = 1'b1;
      end
    end else begin
      nxt.released_count = rc_inc;
      if (cur.debounced_level && (rc_inc > cfg.debounce_ticks)) begin
        nxt.debounced_level = 1'b0;
        if (cur.hold_reported) begin
          ev = bpc_pkg::EV_NONE;
        end else if (cur.pressed_count > cfg.long_press_ticks) begin
          ev = bpc_pkg::EV_LONG;
        end else begin
          ev = bpc_pkg::EV_SHORT;
        end
        nxt.hold_reported = 1'b0;
        nxt.pressed_count = '0;
      end
    end
  end

endmodule

// ----- sv/button_press_classifier.sv -----
// Top level of the button press classifier: state memory, forwarding and output register.
//
// The sample channel carries one word per tick and button: the button index and
// whether it is pressed. The result channel returns exactly one word per sample,
// in order: the same button index and an event code (none, short press, long
// press, hold). Both channels use valid and stall; a word moves at a clock edge
// where valid is high and stall is low.
// Per-button state sits in one RAM entry; each sample is a read, an update and
// a write-back of that entry. A write from the previous sample to the same
// entry is forwarded, so samples for the same button may come back to back.
// One sample per cycle is taken while the result channel does not stall. A sample
// accepted at a clock edge is read from the RAM at that edge, updated in the read
// stage and its result is loaded into the output register when that register advances.
// When the receiver stalls, the result holds in the output register and one
// more sample can wait in the read stage; after that the sample channel stalls.
// Reset clears the control state and per-entry valid bits, so every button
// reads as pressed with a hold already reported until first written; the
// thresholds return to 15, 1000 and 4000. No clearing pass is needed.
// Configuration writes must be made while the block is idle; it does not enforce this.
module button_press_classifier #(
  parameter int NUM_BUTTONS = bpc_pkg::NUM_BUTTONS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  bpc_pkg::sample_t                sample,
  output logic                            result_valid,
  input  logic                            result_stall,
  output bpc_pkg::result_t                result,
  input  logic                            cfg_wr,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int EW = $bits(bpc_pkg::entry_t);

  // Configuration registers.
  bpc_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks   <= bpc_pkg::DEBOUNCE_DEF;
      cfg.long_press_ticks <= bpc_pkg::LONG_DEF;
      cfg.hold_ticks       <= bpc_pkg::HOLD_DEF;
    end else if (cfg_wr) begin
      case (cfg_idx)
        bpc_pkg::CFG_DEBOUNCE: cfg.debounce_ticks   <= cfg_data;
        bpc_pkg::CFG_LONG:     cfg.long_press_ticks <= cfg_data;
        bpc_pkg::CFG_HOLD:     cfg.hold_ticks       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input side: address decode and range check.
  logic [8:0]    btn_ext;
  logic [AW-1:0] in_addr;
  logic          in_range;
  logic          accept;

  assign btn_ext  = {6'd0, sample.button};
  assign in_addr  = btn_ext[AW-1:0];
  assign in_range = btn_ext < 9'(NUM_BUTTONS);

  // Read stage registers.
  logic          s1_v;
  logic          s1_adv;
  logic [bpc_pkg::BTN_W-1:0] s1_btn;
  logic          s1_p;
  logic          s1_inr;
  logic [AW-1:0] s1_addr;
  logic          s1_mvld;

  assign s1_adv       = !result_valid || !result_stall;
  assign sample_stall = s1_v && !s1_adv;
  assign accept       = sample_valid && !sample_stall;

  // Entries never written read as the reset state.
  logic [NUM_BUTTONS-1:0] vld;

  // Forwarding register: the most recent write-back.
  logic            fw_v;
  logic [AW-1:0]   fw_addr;
  bpc_pkg::entry_t fw_data;

  logic [EW-1:0]   rd_data;
  bpc_pkg::entry_t cur;
  bpc_pkg::entry_t nxt;
  logic [1:0]      ev;
  logic            wr_en;

  bpc_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_BUTTONS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_addr),
    .wr_data (nxt),
    .rd_en   (accept),
    .rd_addr (in_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    if (fw_v && (fw_addr == s1_addr)) begin
      cur = fw_data;
    end else if (s1_mvld) begin
      cur = bpc_pkg::entry_t'(rd_data);
    end else begin
      cur = bpc_pkg::ENTRY_RESET;
    end
  end

  bpc_update u_update (
    .cur     (cur),
    .pressed (s1_p),
    .cfg     (cfg),
    .nxt     (nxt),
    .ev      (ev)
  );

  assign wr_en = s1_v && s1_adv && s1_inr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v         <= 1'b0;
      fw_v         <= 1'b0;
      vld          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_v <= 1'b1;
      end else if (s1_adv) begin
        s1_v <= 1'b0;
      end
      if (wr_en) begin
        fw_v          <= 1'b1;
        vld[s1_addr]  <= 1'b1;
      end
      if (s1_adv) begin
        result_valid <= s1_v;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_btn  <= sample.button;
      s1_p    <= sample.pressed;
      s1_inr  <= in_range;
      s1_addr <= in_addr;
      s1_mvld <= vld[in_addr];
    end
    if (wr_en) begin
      fw_addr <= s1_addr;
      fw_data <= nxt;
    end
    if (s1_adv && s1_v) begin
      result.event_button <= s1_btn;
      result.event_res    <= s1_inr ? ev : bpc_pkg::EV_NONE;
    end
  end

endmodule

// ----- sv/bpc_checker.sv -----
// Port-level assertion checker for the button press classifier, bound to the top level.
`include "button_press_classifier_assert.svh"

module bpc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           sample_valid,
  input logic                           sample_stall,
  input bpc_pkg::sample_t               sample,
  input logic                           result_valid,
  input logic                           result_stall,
  input bpc_pkg::result_t               result
);

  // Reset empties the output register.
  `BPC_ASSERT_ALWAYS(a_reset_empty, rst |=> !result_valid, "result valid after reset")

  // The sample side only stalls when a result is waiting and stalled.
  `BPC_ASSERT(a_stall_cause, sample_stall |-> (result_valid && result_stall), "needless stall")

  // When the receiver does not stall the result, an accepted sample comes back for the same button.
  `BPC_ASSERT(a_latency,
    (sample_valid && !sample_stall) ##1 !result_stall |=>
      (result_valid && (result.event_button == $past(sample.button, 2))),
    "result missing or for wrong button")

  // A stalled result holds.
  `BPC_ASSERT(a_hold, (result_valid && result_stall) |=> (result_valid && $stable(result)),
    "stalled result changed")

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (.*);
